[design/bitmap_block_allocator_core_macros.svh]
// Assertion macros used by the checker file of the block allocator.
// Needs nothing else; include with the bare file name.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled during reset.
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bba_pkg.sv]
// Shared types, sizes, status codes and helpers of the bitmap block allocator.
// No dependencies; imported by every module of the block but the generic RAM.
package bba_pkg;

  localparam int MapBits   = 16384;
  localparam int WordBits  = 64;
  localparam int BitPosW   = $clog2(WordBits);
  localparam int NumWords  = (MapBits + WordBits - 1) / WordBits;
  localparam int WordAw    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BitAw     = WordAw + BitPosW;
  localparam int ScanBits  = 16;
  localparam int ScanIdxW  = $clog2(ScanBits);
  localparam int SubChunks = WordBits / ScanBits;
  localparam int SubW      = (SubChunks > 1) ? $clog2(SubChunks) : 1;
  localparam int SumChunks = (NumWords + ScanBits - 1) / ScanBits;
  localparam int SumCw     = (SumChunks > 1) ? $clog2(SumChunks) : 1;
  localparam int SumVecW   = SumChunks * ScanBits;
  localparam int ScanWordW = SumCw + ScanIdxW;
  localparam int CalcW     = 18;

  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_FREE_CHK,
    FSM_SUM_SCAN,
    FSM_RD,
    FSM_WORD,
    FSM_WORD_SCAN,
    FSM_ALLOC_CHK,
    FSM_RESULT
  } fsm_e;

  typedef struct packed {
    logic                found;
    logic [ScanIdxW-1:0] idx;
  } ffs_res_t;

  // Contents of a map word that has not been written since reset: every bit
  // free except the reserved bit zero and any bit past the end of the map.
  function automatic logic [WordBits-1:0] reset_word(input logic [WordAw-1:0] w);
    logic [WordBits-1:0] v;
    v = '0;
    for (int i = 0; i < WordBits; i++) begin
      v[i] = ((int'(w) * WordBits + i) < MapBits) && !((w == '0) && (i == 0));
    end
    return v;
  endfunction

endpackage

[design/bba_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bba_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/bba_ffs.sv]
// Find-first-set unit: lowest set bit of a 16-bit slice.
// Depends on bba_pkg; shared by the summary scan and the word scan.
module bba_ffs
  import bba_pkg::*;
(
  input  logic [ScanBits-1:0] vec_i,
  output ffs_res_t            res_o
);

  always_comb begin
    res_o.found = |vec_i;
    res_o.idx   = '0;
    for (int i = ScanBits - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        res_o.idx = ScanIdxW'(i);
      end
    end
  end

endmodule

[design/bitmap_block_allocator_core.sv]
// Bitmap first-fit block allocator.
// Depends on bba_pkg, bba_ram and bba_ffs.
//
// Requests arrive on the s_axis channel: tuser is the kind (0 allocate,
// 1 free) and tdata carries the block number to free. Each request gives
// exactly one answer on m_axis: tdata is the block number, tuser the status
// (0 done, 1 map full, 2 block or result out of range). cfg_data_i writes the
// block number of map bit one; write it only while no request is in flight.
// The map sits in a 64-bit wide RAM; a flip-flop summary keeps one
// "has a free bit" flag per RAM word and a valid flag per word, so no
// clearing pass is needed after reset. A free request runs FREE_CHK, RD,
// WORD and RESULT, skipping RD and WORD when the block lies outside the map;
// RESULT loads the output register and raises m_axis_tvalid. An allocate
// request walks the summary 16 flags a cycle and then the chosen word 16 bits
// a cycle through one shared find-first-set unit, and answers map full when
// no summary flag is set. s_axis_tready is high only while idle, so the next
// transfer comes at the earliest in the idle cycle after the answer is loaded.
// While the receiver stalls, a finished request waits in the output register
// and the next request may still be accepted and worked on up to its own answer.
// Reset leaves bit 0 used, all others free, and the register at zero.
module bitmap_block_allocator_core
  import bba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] block_number
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] block_number_res
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  fsm_e state_q, state_d;

  logic                kind_q;
  logic [15:0]         blk_q;
  logic [15:0]         fdz_q;
  logic [SumCw-1:0]    chunk_q;
  logic [SubW-1:0]     sub_q;
  logic [WordAw-1:0]   word_q;
  logic [BitPosW-1:0]  bit_q;
  logic [WordBits-1:0] wdata_q;
  logic [15:0]         res_blk_q;
  logic [1:0]          res_st_q;
  logic                m_valid_q;
  logic [15:0]         m_blk_q;
  logic [1:0]          m_st_q;
  logic [NumWords-1:0] valid_q;
  logic [NumWords-1:0] summary_q;

  logic                s_accept;
  logic                out_free;
  logic [SumVecW-1:0]  sum_vec;
  logic [ScanBits-1:0] ffs_vec;
  ffs_res_t            ffs_res;
  logic [ScanWordW-1:0] scan_word;
  logic [WordBits-1:0] ram_rdata;
  logic [WordBits-1:0] cur_word;
  logic [WordBits-1:0] bit_mask;
  logic [CalcW-1:0]    free_idx;
  logic                free_range_err;
  logic [CalcW-1:0]    alloc_res;
  logic                alloc_range_err;
  logic                chunk_last;
  logic                sub_last;
  logic                ram_we;
  logic [WordBits-1:0] ram_wdata;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign sum_vec   = SumVecW'(summary_q);
  assign scan_word = {chunk_q, ffs_res.idx};
  assign cur_word  = valid_q[word_q] ? ram_rdata : reset_word(word_q);
  assign bit_mask  = WordBits'(1) << bit_q;
  assign chunk_last = (chunk_q == SumCw'(SumChunks - 1));
  assign sub_last   = (sub_q == SubW'(SubChunks - 1));

  // Free: map bit = block - first_data_zone + 1, negative when bit 17 is set.
  assign free_idx       = {2'b00, blk_q} - {2'b00, fdz_q} + CalcW'(1);
  assign free_range_err = free_idx[CalcW-1] || (free_idx[16:0] >= 17'(MapBits));

  // Allocate: result = first_data_zone + k - 1 must stay within 16 bits.
  assign alloc_res       = {2'b00, fdz_q} + CalcW'({word_q, bit_q}) - CalcW'(1);
  assign alloc_range_err = alloc_res[CalcW-1] || alloc_res[16];

  bba_ffs u_ffs (
    .vec_i (ffs_vec),
    .res_o (ffs_res)
  );

  bba_ram #(
    .Width (WordBits),
    .Depth (NumWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata),
    .raddr_i (word_q),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (s_accept) begin
          state_d = (s_axis_tuser[0] == KindFree) ? FSM_FREE_CHK : FSM_SUM_SCAN;
        end
      end
      FSM_FREE_CHK: state_d = free_range_err ? FSM_RESULT : FSM_RD;
      FSM_SUM_SCAN: begin
        if (ffs_res.found) begin
          state_d = FSM_RD;
        end else if (chunk_last) begin
          state_d = FSM_RESULT;
        end
      end
      FSM_RD:   state_d = FSM_WORD;
      FSM_WORD: state_d = (kind_q == KindFree) ? FSM_RESULT : FSM_WORD_SCAN;
      FSM_WORD_SCAN: begin
        if (ffs_res.found) begin
          state_d = FSM_ALLOC_CHK;
        end else if (sub_last) begin
          state_d = FSM_RESULT;
        end
      end
      FSM_ALLOC_CHK: state_d = FSM_RESULT;
      FSM_RESULT: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs of the sequencer: scan unit input, RAM write and s_axis_tready.
  always_comb begin
    ffs_vec       = '0;
    ram_we        = 1'b0;
    ram_wdata     = cur_word | bit_mask;
    s_axis_tready = 1'b0;
    unique case (state_q)
      FSM_IDLE:      s_axis_tready = 1'b1;
      FSM_SUM_SCAN:  ffs_vec = sum_vec[int'(chunk_q) * ScanBits +: ScanBits];
      FSM_WORD_SCAN: ffs_vec = wdata_q[int'(sub_q) * ScanBits +: ScanBits];
      FSM_WORD: begin
        ram_we    = (kind_q == KindFree);
        ram_wdata = cur_word | bit_mask;
      end
      FSM_ALLOC_CHK: begin
        ram_we    = !alloc_range_err;
        ram_wdata = wdata_q & ~bit_mask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FSM_IDLE: begin
        if (s_accept) begin
          kind_q <= s_axis_tuser[0];
          blk_q  <= s_axis_tdata;
        end
        chunk_q <= '0;
      end
      FSM_FREE_CHK: begin
        word_q    <= free_idx[BitAw-1:BitPosW];
        bit_q     <= free_idx[BitPosW-1:0];
        res_blk_q <= blk_q;
        res_st_q  <= free_range_err ? StatRange : StatDone;
      end
      FSM_SUM_SCAN: begin
        if (ffs_res.found) begin
          word_q <= scan_word[WordAw-1:0];
        end else if (chunk_last) begin
          res_blk_q <= '0;
          res_st_q  <= StatFull;
        end else begin
          chunk_q <= chunk_q + SumCw'(1);
        end
      end
      FSM_WORD: begin
        wdata_q <= cur_word;
        sub_q   <= '0;
      end
      FSM_WORD_SCAN: begin
        if (ffs_res.found) begin
          bit_q <= BitPosW'({sub_q, ffs_res.idx});
        end else begin
          sub_q <= sub_q + SubW'(1);
          if (sub_last) begin
            res_blk_q <= '0;
            res_st_q  <= StatFull;
          end
        end
      end
      FSM_ALLOC_CHK: begin
        res_blk_q <= alloc_range_err ? 16'd0 : alloc_res[15:0];
        res_st_q  <= alloc_range_err ? StatRange : StatDone;
      end
      default: ;
    endcase
  end

  // Per-word valid and free-summary flags follow every RAM write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      summary_q <= '1;
    end else if (ram_we) begin
      valid_q[word_q]   <= 1'b1;
      summary_q[word_q] <= |ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdz_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fdz_q <= cfg_data_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == FSM_RESULT) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == FSM_RESULT) && out_free) begin
      m_blk_q <= res_blk_q;
      m_st_q  <= res_st_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_blk_q;
  assign m_axis_tuser  = m_st_q;

endmodule

[design/bba_checker.sv]
// Port-level checks of the block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_core_macros.svh.
`include "bitmap_block_allocator_core_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled answer keeps its content until it is taken.
  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser);
  endproperty

  // A request is worked on alone: no second transfer in the next cycle.
  property p_busy_after_accept;
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready;
  endproperty

  // A full map answers with block number zero.
  property p_full_zero;
    m_axis_tvalid && (m_axis_tuser == StatFull) |-> m_axis_tdata == 16'd0;
  endproperty

  // No answer can appear earlier than the shortest request path.
  property p_no_early_answer;
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid;
  endproperty

  `BBA_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled answer changed")
  `BBA_ASSERT(a_busy_after_accept, clk_i, rst_ni, p_busy_after_accept, "ready after a transfer")
  `BBA_ASSERT(a_full_zero, clk_i, rst_ni, p_full_zero, "full map answer has a block number")
  `BBA_ASSERT(a_no_early_answer, clk_i, rst_ni, p_no_early_answer, "answer right after transfer")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);

[verif/tb_alloc_pkg.sv]
// Answer type and scoreboard for the bitmap block allocator testbench.
// Depends on bba_pkg for the map size, request kinds and status codes.
package alloc_check_pkg;
  import bba_pkg::*;

  typedef struct packed {
    logic [15:0] blk_no;
    logic [1:0]  status;
  } answer_t;

  class alloc_scoreboard;
    bit [7:0]    free_bytes [MapBits/8];
    int          scan_from;
    int          free_left;
    logic [15:0] zone;
    answer_t     answers_due [$];
    int          answers_seen;
    int          errors;

    function new();
      foreach (free_bytes[i]) free_bytes[i] = 8'hFF;
      // Bit 0 is reserved and starts out used.
      free_bytes[0] = 8'h7F;
      scan_from = 0;
      free_left = MapBits - 1;
      zone = 16'd0;
      answers_seen = 0;
      errors = 0;
    endfunction

    function void set_zone(logic [15:0] value);
      zone = value;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function bit map_full();
      return free_left == 0;
    endfunction

    // Works out the answer to one accepted request and updates the map.
    function void note_request(logic kind, logic [15:0] blk);
      answer_t want;
      int k;
      int r;
      int idx;
      if (kind == KindAlloc) begin
        k = -1;
        // Bytes below scan_from are known to be all used.
        for (int i = scan_from; i < MapBits/8 && k < 0; i++) begin
          if (free_bytes[i] != 8'h00) begin
            scan_from = i;
            for (int p = 0; p < 8 && k < 0; p++) begin
              if (free_bytes[i][7-p]) k = i * 8 + p;
            end
          end
        end
        if (k < 0) begin
          scan_from = MapBits/8;
          want = '{16'd0, StatFull};
        end else begin
          r = int'(zone) + k - 1;
          if (r < 0 || r > 65535) begin
            want = '{16'd0, StatRange};
          end else begin
            free_bytes[k >> 3][7 - (k & 7)] = 1'b0;
            free_left--;
            want = '{r[15:0], StatDone};
          end
        end
      end else begin
        idx = int'(blk) - int'(zone) + 1;
        if (idx < 0 || idx >= MapBits) begin
          want = '{blk, StatRange};
        end else begin
          if (!free_bytes[idx >> 3][7 - (idx & 7)]) free_left++;
          free_bytes[idx >> 3][7 - (idx & 7)] = 1'b1;
          if ((idx >> 3) < scan_from) scan_from = idx >> 3;
          want = '{blk, StatDone};
        end
      end
      answers_due.push_back(want);
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= 10) begin
        $display("answer %0d: %s expected %0d, got %0d", answers_seen, what, want, got);
      end
    endfunction

    function void check_answer(logic [15:0] blk, logic [1:0] status);
      answer_t want;
      answers_seen++;
      if (answers_due.size() == 0) begin
        flag("block_number_res with no request pending:", 16'd0, blk);
        return;
      end
      want = answers_due.pop_front();
      if (blk !== want.blk_no) flag("block_number_res", want.blk_no, blk);
      if (status !== want.status) flag("status", 16'(want.status), 16'(status));
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
// Top-level testbench of the bitmap block allocator: directed corner cases, random
// alloc/free traffic under several zone settings, then requests at the map's edges.
// Depends on bba_pkg, alloc_check_pkg and the allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;
  import alloc_check_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int ChunkItems = 290;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] block_number
  logic [0:0]  s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] block_number_res
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  logic            steady;
  int              quiet_cycles;
  alloc_scoreboard book;

  bitmap_block_allocator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // The receiver stalls with a chance of 16 in a hundred unless the run is steady.
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        book.check_answer(m_axis_tdata, m_axis_tuser);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic kind, input logic [15:0] blk);
    while (!steady && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= blk;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_request(kind, blk);
    @(negedge clk_i);
  endtask

  // The zone register is only written once every answer has come back.
  task automatic write_zone(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    book.set_zone(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] chunk_zone [5];
    int          sel;
    int          idx;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    s_axis_tuser  = KindAlloc;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 16'd0;
    steady        = 1'b0;
    quiet_cycles  = 0;
    book = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zone at its reset value of zero.
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'h0000);
    send_request(KindFree, 16'd0);
    send_request(KindFree, 16'hFFFF);     // past the end of the map
    send_request(KindFree, 16'd5);        // already free
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'hFFFF);

    // Highest zone: the reserved bit is freed and results run past 16 bits.
    write_zone(16'hFFFF);
    send_request(KindFree, 16'hFFFE);
    send_request(KindFree, 16'hFFFF);
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'h0000);
    send_request(KindFree, 16'd0);        // below the map

    // Free bit 0, then with zone zero its block number would be negative.
    write_zone(16'd1);
    send_request(KindFree, 16'd0);
    write_zone(16'd0);
    send_request(KindAlloc, 16'h0000);
    write_zone(16'd1);
    send_request(KindAlloc, 16'h0000);

    chunk_zone[0] = 16'd0;
    chunk_zone[1] = 16'd1000;
    chunk_zone[2] = 16'($urandom_range(2, 60000));
    chunk_zone[3] = 16'd49153;
    chunk_zone[4] = 16'hFFFF;
    for (int c = 0; c < 5; c++) begin
      write_zone(chunk_zone[c]);
      steady <= (c == 1);
      for (int n = 0; n < ChunkItems; n++) begin
        if ($urandom_range(99) < 55) begin
          send_request(KindAlloc, 16'($urandom));
        end else begin
          // Most frees land in the low, busy part of the map.
          sel = $urandom_range(99);
          if (sel < 65) begin
            idx = $urandom_range(0, 511);
          end else if (sel < 80) begin
            idx = $urandom_range(0, MapBits - 1);
          end else if (sel < 90) begin
            idx = ($urandom_range(1)) ? MapBits - 2 + $urandom_range(0, 2)
                                      : $urandom_range(0, 1) - 1;
          end else begin
            idx = $urandom_range(0, 65535) - int'(chunk_zone[c]) + 1;
          end
          send_request(KindFree, 16'(int'(chunk_zone[c]) + idx - 1));
        end
      end
    end

    // Work at the edges of the map with the zone at 1000.
    write_zone(16'd1000);
    steady <= 1'b0;
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'hFFFF);
    send_request(KindFree, 16'd999);
    send_request(KindFree, 16'(1000 + MapBits - 2));
    send_request(KindFree, 16'(1000 + MapBits - 1));
    send_request(KindFree, 16'd998);
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'h0000);
    send_request(KindAlloc, 16'h0000);

    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[bitmap_block_allocator_core.f]
+incdir+design
design/bba_pkg.sv
design/bba_ram.sv
design/bba_ffs.sv
design/bitmap_block_allocator_core.sv
design/bba_checker.sv
verif/tb_alloc_pkg.sv
verif/tb_top.sv
